[src/tmh_pkg.sv]
// ----------------------------------------------------------------------------
// tmh_pkg: shared types and codes of the timer min-heap
// Operation and status codes, controller states and the command struct that
// the controller broadcasts along the row of heap level cells.
// ----------------------------------------------------------------------------
package tmh_pkg;

	// fixed field widths of the stream payload
	localparam int ID_W       = 6;
	localparam int IN_DATA_W  = 72;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 152;
	localparam int OUT_USER_W = 3;

	// level numbers up to ten (capacity up to 1024)
	localparam int LVL_BITS = 4;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2
	} tmh_op_t;

	typedef enum logic [2:0] {
		STAT_OK    = 3'd0,
		STAT_EMPTY = 3'd1,
		STAT_NO_ID = 3'd2,
		STAT_FULL  = 3'd3,
		STAT_DUP   = 3'd4
	} tmh_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_LAST,
		S_SU_RD,
		S_SU_CMP,
		S_SD_RD,
		S_SD_CMP,
		S_DONE
	} tmh_state_t;

	// per-cycle heap command: which level reads and which level writes
	typedef struct packed {
		logic                rd_en;
		logic [LVL_BITS-1:0] rd_lvl;
		logic                wr_en;
		logic [LVL_BITS-1:0] wr_lvl;
	} tmh_ctl_t;

endpackage

[src/tmh_ram.sv]
// ----------------------------------------------------------------------------
// tmh_ram: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module tmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]                        rd_data_a,
	output logic [WIDTH-1:0]                        rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

[src/tmh_cell.sv]
// ----------------------------------------------------------------------------
// tmh_cell: one level of the heap
// Holds the entries of one tree level, answers reads addressed to its level
// and passes the read data of deeper levels on toward the root.
// ----------------------------------------------------------------------------
module tmh_cell #(
	parameter int LEVEL    = 0,
	parameter int CAPACITY = 64,
	parameter int WIDTH    = 70,
	parameter int IDX_BITS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tmh_pkg::tmh_ctl_t    ctl,
	input  logic [IDX_BITS-1:0]  rd_idx_a,
	input  logic [IDX_BITS-1:0]  rd_idx_b,
	input  logic [IDX_BITS-1:0]  wr_idx,
	input  logic [WIDTH-1:0]     wr_data,
	input  logic [WIDTH-1:0]     chain_in_a,
	input  logic [WIDTH-1:0]     chain_in_b,
	output logic [WIDTH-1:0]     chain_out_a,
	output logic [WIDTH-1:0]     chain_out_b
);

	localparam int LW    = tmh_pkg::LVL_BITS;
	localparam int BASE  = 1 << LEVEL;
	localparam int DEPTH = ((CAPACITY - BASE + 1) < BASE) ? (CAPACITY - BASE + 1) : BASE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic             wr_hit;
	logic             sel_q;
	logic [WIDTH-1:0] ram_a;
	logic [WIDTH-1:0] ram_b;

	assign wr_hit = ctl.wr_en && (ctl.wr_lvl == LW'(LEVEL));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else begin
			sel_q <= ctl.rd_en && (ctl.rd_lvl == LW'(LEVEL));
		end
	end

	tmh_ram #(
		.WIDTH (WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_hit),
		.wr_addr   (AW'(wr_idx)),
		.wr_data   (wr_data),
		.rd_addr_a (AW'(rd_idx_a)),
		.rd_addr_b (AW'(rd_idx_b)),
		.rd_data_a (ram_a),
		.rd_data_b (ram_b)
	);

	// own data when this level was read, else pass deeper data on
	assign chain_out_a = sel_q ? ram_a : chain_in_a;
	assign chain_out_b = sel_q ? ram_b : chain_in_b;

endmodule

[src/timer_min_heap_top.sv]
// Throughput: one request at a time, the next can be taken in the cycle after its result loads;
// each heap level a sift crosses costs a read of the level cell and then a compare-and-write.
// A result still held on the output stalls the next load.
// Reset: arst_n clears the count, the id presence bits and the handshake state at once.
// ----------------------------------------------------------------------------
// timer_min_heap_top: binary min-heap of timers with removal by id
// The heap is a row of level cells, one per tree level. A sifting entry moves
// cell to cell while the controller compares it with its parent or children.
// A slot RAM maps each timer id to its node so that a timer can be removed.
// ----------------------------------------------------------------------------
module timer_min_heap_top #(
	parameter int CAPACITY = 64,
	parameter int ID_COUNT = 64,
	parameter int KEY_BITS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [5:0] timer_id, [69:6] expire_time, [71:70] zero
	input  logic [tmh_pkg::IN_DATA_W-1:0]    s_tdata,
	// [1:0] op
	input  logic [tmh_pkg::IN_USER_W-1:0]    s_tuser,
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [5:0] popped_id, [69:6] popped_expire, [70] top_valid, [76:71] top_id,
	// [140:77] top_expire, [147:141] entry_count, [151:148] zero
	output logic [tmh_pkg::OUT_DATA_W-1:0]   m_tdata,
	// [2:0] status
	output logic [tmh_pkg::OUT_USER_W-1:0]   m_tuser
);

	localparam int NODE_BITS = $clog2(CAPACITY + 1);
	localparam int IDX_BITS  = NODE_BITS - 1;
	localparam int LEVELS    = NODE_BITS;
	localparam int IDA_BITS  = $clog2(ID_COUNT);
	localparam int ID_W      = tmh_pkg::ID_W;
	localparam int ENT_W     = KEY_BITS + ID_W;
	localparam int LW        = tmh_pkg::LVL_BITS;

	// tree level of a node number (root is node 1)
	function automatic logic [LW-1:0] lvl_of(input logic [NODE_BITS-1:0] n);
		logic [LW-1:0] r;
		r = '0;
		for (int i = 0; i < NODE_BITS; i++) begin
			if (n[i]) r = LW'(i);
		end
		return r;
	endfunction

	// place of a node within its level: drop the leading one
	function automatic logic [IDX_BITS-1:0] idx_of(input logic [NODE_BITS-1:0] n);
		logic [NODE_BITS-1:0] lead;
		lead = NODE_BITS'(1) << lvl_of(n);
		return IDX_BITS'(n ^ lead);
	endfunction

	// control state
	tmh_pkg::tmh_state_t state_q, state_d;
	logic [NODE_BITS-1:0] count_q;
	logic [ID_COUNT-1:0]  present_q;
	logic                 out_valid_q;

	// request and sift registers
	logic [1:0]           op_q;
	logic [ID_W-1:0]      id_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [NODE_BITS-1:0] node_q;
	logic [KEY_BITS-1:0]  tok_key_q;
	logic [ID_W-1:0]      tok_id_q;
	logic                 rm_q;
	logic                 r_ex_q;
	tmh_pkg::tmh_status_t status_q;
	logic [ID_W-1:0]      pid_q;
	logic [KEY_BITS-1:0]  pkey_q;
	logic [KEY_BITS-1:0]  top_key_q;
	logic [ID_W-1:0]      top_id_q;
	logic [tmh_pkg::OUT_DATA_W-1:0] out_data_q;
	logic [tmh_pkg::OUT_USER_W-1:0] out_user_q;

	// decode
	logic                 accept;
	logic                 id_ok;
	logic                 is_present;
	logic                 full;
	logic                 push_ok;
	logic                 pop_ok;
	logic                 rem_ok;
	logic                 last_fetch;
	logic [NODE_BITS-1:0] slot_node;
	logic                 load;

	// heap read data and compares
	logic [ENT_W-1:0]     chain_a [LEVELS+1];
	logic [ENT_W-1:0]     chain_b [LEVELS+1];
	logic [KEY_BITS-1:0]  key_a;
	logic [KEY_BITS-1:0]  key_b;
	logic [ID_W-1:0]      id_a;
	logic [ID_W-1:0]      id_b;
	logic                 par_le;
	logic                 l_ex;
	logic                 r_ex;
	logic                 l_lt;
	logic                 r_lt;
	logic                 r_lt_l;
	logic                 take_r;
	logic                 move;
	logic [NODE_BITS-1:0] child_node;

	// heap commands
	logic                 hrd_en;
	logic [NODE_BITS-1:0] hrd_node;
	logic                 hwr_en;
	logic [NODE_BITS-1:0] hwr_node;
	logic [KEY_BITS-1:0]  hwr_key;
	logic [ID_W-1:0]      hwr_id;
	tmh_pkg::tmh_ctl_t    ctl;
	logic [IDX_BITS-1:0]  rd_idx_a;
	logic [IDX_BITS-1:0]  rd_idx_b;
	logic [IDX_BITS-1:0]  wr_idx;

	logic                 top_valid;

	assign accept     = s_tvalid && s_tready;
	assign s_tready   = (state_q == tmh_pkg::S_IDLE);

	assign id_ok      = (32'(id_q) < ID_COUNT);
	assign is_present = id_ok && present_q[IDA_BITS'(id_q)];
	assign full       = (count_q >= NODE_BITS'(CAPACITY));
	assign push_ok    = !full && id_ok && !is_present;
	assign pop_ok     = (count_q != '0);
	assign rem_ok     = is_present;

	// fetch the last entry when a hole must be filled
	assign last_fetch = ((op_q == tmh_pkg::OP_POP) && pop_ok
				&& (count_q != NODE_BITS'(1)))
			|| ((op_q == tmh_pkg::OP_REMOVE) && rem_ok && (slot_node != count_q));

	// read data ripples up the row of cells toward the root
	assign chain_a[LEVELS] = '0;
	assign chain_b[LEVELS] = '0;
	assign key_a = chain_a[0][KEY_BITS-1:0];
	assign id_a  = chain_a[0][ENT_W-1:KEY_BITS];
	assign key_b = chain_b[0][KEY_BITS-1:0];
	assign id_b  = chain_b[0][ENT_W-1:KEY_BITS];

	// sift up: stop when the parent is not larger
	assign par_le = (key_a <= tok_key_q);

	// sift down: children present, left wins ties
	assign l_ex   = ({node_q, 1'b0} <= {1'b0, count_q});
	assign r_ex   = ({node_q, 1'b1} <= {1'b0, count_q});
	assign l_lt   = (key_a < tok_key_q);
	assign r_lt   = r_ex_q && (key_b < tok_key_q);
	assign r_lt_l = r_ex_q && (key_b < key_a);
	assign take_r = l_lt ? r_lt_l : r_lt;
	assign move   = l_lt || r_lt;
	assign child_node = NODE_BITS'({node_q, take_r});

	assign load = (state_q == tmh_pkg::S_DONE) && (!out_valid_q || m_tready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tmh_pkg::S_IDLE: begin
				if (accept) state_d = tmh_pkg::S_DECODE;
			end
			tmh_pkg::S_DECODE: begin
				if ((op_q == tmh_pkg::OP_PUSH) && push_ok) begin
					state_d = tmh_pkg::S_SU_RD;
				end else if (last_fetch) begin
					state_d = tmh_pkg::S_LAST;
				end else begin
					state_d = tmh_pkg::S_DONE;
				end
			end
			tmh_pkg::S_LAST: begin
				state_d = (node_q == NODE_BITS'(1)) ? tmh_pkg::S_SD_RD : tmh_pkg::S_SU_RD;
			end
			tmh_pkg::S_SU_RD: begin
				state_d = (node_q == NODE_BITS'(1)) ? tmh_pkg::S_DONE : tmh_pkg::S_SU_CMP;
			end
			tmh_pkg::S_SU_CMP: begin
				if (!par_le) begin
					state_d = tmh_pkg::S_SU_RD;
				end else if (rm_q) begin
					state_d = tmh_pkg::S_SD_RD;
				end else begin
					state_d = tmh_pkg::S_DONE;
				end
			end
			tmh_pkg::S_SD_RD: begin
				state_d = l_ex ? tmh_pkg::S_SD_CMP : tmh_pkg::S_DONE;
			end
			tmh_pkg::S_SD_CMP: begin
				state_d = move ? tmh_pkg::S_SD_RD : tmh_pkg::S_DONE;
			end
			tmh_pkg::S_DONE: begin
				if (load) state_d = tmh_pkg::S_IDLE;
			end
			default: state_d = tmh_pkg::S_IDLE;
		endcase
	end

	// heap read and write commands
	always_comb begin
		hrd_en   = 1'b0;
		hrd_node = count_q;
		hwr_en   = 1'b0;
		hwr_node = node_q;
		hwr_key  = tok_key_q;
		hwr_id   = tok_id_q;
		unique case (state_q)
			tmh_pkg::S_DECODE: begin
				hrd_en = last_fetch;
			end
			tmh_pkg::S_SU_RD: begin
				if (node_q == NODE_BITS'(1)) begin
					hwr_en = 1'b1;
				end else begin
					hrd_en   = 1'b1;
					hrd_node = node_q >> 1;
				end
			end
			tmh_pkg::S_SU_CMP: begin
				if (par_le) begin
					// first compare of a remove may turn to sift down instead
					hwr_en = !rm_q;
				end else begin
					hwr_en  = 1'b1;
					hwr_key = key_a;
					hwr_id  = id_a;
				end
			end
			tmh_pkg::S_SD_RD: begin
				if (l_ex) begin
					hrd_en   = 1'b1;
					hrd_node = NODE_BITS'({node_q, 1'b0});
				end else begin
					hwr_en = 1'b1;
				end
			end
			tmh_pkg::S_SD_CMP: begin
				hwr_en = 1'b1;
				if (move) begin
					hwr_key = take_r ? key_b : key_a;
					hwr_id  = take_r ? id_b : id_a;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ctl.rd_en  = hrd_en;
		ctl.rd_lvl = lvl_of(hrd_node);
		ctl.wr_en  = hwr_en;
		ctl.wr_lvl = lvl_of(hwr_node);
	end

	assign rd_idx_a = idx_of(hrd_node);
	assign rd_idx_b = rd_idx_a | IDX_BITS'(1);
	assign wr_idx   = idx_of(hwr_node);

	// one cell per tree level
	for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
		tmh_cell #(
			.LEVEL    (l),
			.CAPACITY (CAPACITY),
			.WIDTH    (ENT_W),
			.IDX_BITS (IDX_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.rd_idx_a    (rd_idx_a),
			.rd_idx_b    (rd_idx_b),
			.wr_idx      (wr_idx),
			.wr_data     ({hwr_id, hwr_key}),
			.chain_in_a  (chain_a[l+1]),
			.chain_in_b  (chain_b[l+1]),
			.chain_out_a (chain_a[l]),
			.chain_out_b (chain_b[l])
		);
	end

	// node of each timer id; every heap write moves its entry's node too.
	// Read at the request edge so the node is ready in decode.
	tmh_ram #(
		.WIDTH (NODE_BITS),
		.DEPTH (ID_COUNT)
	) u_slot_ram (
		.clk       (clk),
		.wr_en     (hwr_en),
		.wr_addr   (IDA_BITS'(hwr_id)),
		.wr_data   (hwr_node),
		.rd_addr_a (IDA_BITS'(s_tdata[ID_W-1:0])),
		.rd_addr_b ('0),
		.rd_data_a (slot_node),
		.rd_data_b ()
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tmh_pkg::S_IDLE;
			count_q     <= '0;
			present_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tmh_pkg::S_DECODE) begin
				unique case (op_q)
					tmh_pkg::OP_PUSH: begin
						if (push_ok) begin
							count_q                     <= count_q + NODE_BITS'(1);
							present_q[IDA_BITS'(id_q)] <= 1'b1;
						end
					end
					tmh_pkg::OP_POP: begin
						if (pop_ok) begin
							count_q                         <= count_q - NODE_BITS'(1);
							present_q[IDA_BITS'(top_id_q)] <= 1'b0;
						end
					end
					tmh_pkg::OP_REMOVE: begin
						if (rem_ok) begin
							count_q                     <= count_q - NODE_BITS'(1);
							present_q[IDA_BITS'(id_q)] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign top_valid = (count_q != '0);

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser[1:0];
			id_q  <= s_tdata[ID_W-1:0];
			key_q <= KEY_BITS'(s_tdata[ID_W+63:ID_W]);
		end
		unique case (state_q)
			tmh_pkg::S_DECODE: begin
				rm_q      <= (op_q == tmh_pkg::OP_REMOVE);
				tok_key_q <= key_q;
				tok_id_q  <= id_q;
				pid_q     <= '0;
				pkey_q    <= '0;
				status_q  <= tmh_pkg::STAT_OK;
				node_q    <= count_q + NODE_BITS'(1);
				unique case (op_q)
					tmh_pkg::OP_PUSH: begin
						if (full) begin
							status_q <= tmh_pkg::STAT_FULL;
						end else if (!id_ok) begin
							status_q <= tmh_pkg::STAT_NO_ID;
						end else if (is_present) begin
							status_q <= tmh_pkg::STAT_DUP;
						end
					end
					tmh_pkg::OP_POP: begin
						node_q <= NODE_BITS'(1);
						if (pop_ok) begin
							pid_q  <= top_id_q;
							pkey_q <= top_key_q;
						end else begin
							status_q <= tmh_pkg::STAT_EMPTY;
						end
					end
					tmh_pkg::OP_REMOVE: begin
						node_q <= slot_node;
						if (!rem_ok) status_q <= tmh_pkg::STAT_NO_ID;
					end
					default: begin
					end
				endcase
			end
			tmh_pkg::S_LAST: begin
				// last entry fills the hole
				tok_key_q <= key_a;
				tok_id_q  <= id_a;
			end
			tmh_pkg::S_SU_CMP: begin
				rm_q <= 1'b0;
				if (!par_le) node_q <= node_q >> 1;
			end
			tmh_pkg::S_SD_RD: begin
				r_ex_q <= r_ex;
			end
			tmh_pkg::S_SD_CMP: begin
				if (move) node_q <= child_node;
			end
			default: begin
			end
		endcase
		// shadow the root for the top fields and pop
		if (hwr_en && (hwr_node == NODE_BITS'(1))) begin
			top_key_q <= hwr_key;
			top_id_q  <= hwr_id;
		end
		if (load) begin
			out_user_q <= status_q;
			out_data_q <= {
				4'b0,
				7'(count_q),
				top_valid ? 64'(top_key_q) : 64'b0,
				top_valid ? top_id_q : 6'b0,
				top_valid,
				64'(pkey_q),
				pid_q
			};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// one presence bit set for each timer in the heap
	a_count_present: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(present_q) == int'(count_q))
		else $error("presence bits disagree with entry count");

	// heap writes stay within the occupied nodes
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		hwr_en |-> (hwr_node != '0) && (hwr_node <= count_q))
		else $error("heap write outside occupied nodes");

	// a fresh result reports the count held after its request
	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (m_tdata[147:141] == 7'(count_q)))
		else $error("result count differs from heap count");

	// sift down compares only where a left child exists
	a_sd_child: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tmh_pkg::S_SD_RD) && l_ex |=> (state_q == tmh_pkg::S_SD_CMP) && $stable(node_q))
		else $error("sift down lost its node");

endmodule

[tb/timer_min_heap_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_min_heap_top_test: self-checking bench for the timer min-heap
// Sends push, pop and remove requests, predicts every result with a
// behavioral heap of its own and checks each result field by field, under
// random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module timer_min_heap_top_test;
	import tmh_pkg::*;

	localparam int HEAP_CAP        = 64;
	localparam int HEAP_IDS        = 64;
	localparam int KEY_W           = 64;
	localparam int STALL_LIMIT     = 4000;  // cycles with no transfer on either stream
	localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall of the pressure test
	localparam int DRAIN_CYCLES    = 40;    // more than the worst request latency
	localparam int RANDOM_ITEMS    = 1250;
	localparam int TAIL_ITEMS      = 150;

	// op code 3 has no meaning; the block treats it as a no-op
	localparam logic [1:0] OP_NOP = 2'd3;

	// one result as it travels on the result stream
	typedef struct packed {
		tmh_status_t          status;
		logic [ID_W-1:0]      popped_id;
		logic [KEY_W-1:0]     popped_expire;
		logic                 top_valid;
		logic [ID_W-1:0]      top_id;
		logic [KEY_W-1:0]     top_expire;
		logic [6:0]           entry_count;
	} heap_report_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [IN_USER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	// predicted heap: keys and ids per node, node of each id, live ids, size
	logic [KEY_W-1:0] heap_key [HEAP_CAP];
	logic [ID_W-1:0]  heap_tid [HEAP_CAP];
	int               node_of_id [HEAP_IDS];
	bit               id_live [HEAP_IDS];
	int               heap_size = 0;

	// results predicted at request acceptance, oldest first
	heap_report_t awaited_reports [$];

	int error_count   = 0;
	int src_gap_pct   = 20;  // chance of an idle burst before each request
	int sink_gap_pct  = 20;  // chance of a stall burst on the result side
	int sink_hold_len = 0;   // nonzero asks the result side for one long stall

	timer_min_heap_top #(
		.CAPACITY(HEAP_CAP),
		.ID_COUNT(HEAP_IDS),
		.KEY_BITS(KEY_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Behavioral heap
	// ------------------------------------------------------------------------

	function automatic void place_entry(int slot, logic [KEY_W-1:0] key, logic [ID_W-1:0] tid);
		heap_key[slot] = key;
		heap_tid[slot] = tid;
		node_of_id[tid] = slot;
	endfunction

	function automatic void swap_nodes(int a, int b);
		logic [KEY_W-1:0] ka;
		logic [ID_W-1:0]  ta;
		ka = heap_key[a];
		ta = heap_tid[a];
		place_entry(a, heap_key[b], heap_tid[b]);
		place_entry(b, ka, ta);
	endfunction

	// move an entry up while its parent is strictly larger; ties stay below
	function automatic void sift_toward_root(int slot);
		int  parent;
		bit  settled;
		settled = 1'b0;
		while (slot > 0 && !settled) begin
			parent = (slot - 1) / 2;
			if (heap_key[parent] <= heap_key[slot]) begin
				settled = 1'b1;
			end else begin
				swap_nodes(parent, slot);
				slot = parent;
			end
		end
	endfunction

	// move an entry down to its smallest child; the left child wins ties
	function automatic void sift_toward_leaves(int slot);
		int lc;
		int rc;
		int pick;
		bit settled;
		settled = 1'b0;
		while (!settled) begin
			lc   = 2 * slot + 1;
			rc   = 2 * slot + 2;
			pick = slot;
			if (lc < heap_size && heap_key[lc] < heap_key[pick])
				pick = lc;
			if (rc < heap_size && heap_key[rc] < heap_key[pick])
				pick = rc;
			if (pick == slot) begin
				settled = 1'b1;
			end else begin
				swap_nodes(slot, pick);
				slot = pick;
			end
		end
	endfunction

	// apply one request to the heap and return the result it must produce
	function automatic heap_report_t apply_timer_op(logic [1:0] op, logic [ID_W-1:0] tid,
			logic [KEY_W-1:0] key);
		heap_report_t rep;
		int           slot;
		rep = '0;
		case (op)
			OP_PUSH: begin
				if (heap_size >= HEAP_CAP) begin
					rep.status = STAT_FULL;
				end else if (id_live[tid]) begin
					rep.status = STAT_DUP;
				end else begin
					slot = heap_size;
					heap_size++;
					place_entry(slot, key, tid);
					id_live[tid] = 1'b1;
					sift_toward_root(slot);
				end
			end
			OP_POP: begin
				if (heap_size == 0) begin
					rep.status = STAT_EMPTY;
				end else begin
					rep.popped_id     = heap_tid[0];
					rep.popped_expire = heap_key[0];
					id_live[heap_tid[0]] = 1'b0;
					heap_size--;
					if (heap_size > 0) begin
						place_entry(0, heap_key[heap_size], heap_tid[heap_size]);
						sift_toward_leaves(0);
					end
				end
			end
			OP_REMOVE: begin
				if (!id_live[tid]) begin
					rep.status = STAT_NO_ID;
				end else begin
					slot = node_of_id[tid];
					id_live[tid] = 1'b0;
					heap_size--;
					// fill the hole with the last entry unless the hole was the last node
					if (slot < heap_size) begin
						place_entry(slot, heap_key[heap_size], heap_tid[heap_size]);
						if (slot > 0 && heap_key[slot] < heap_key[(slot - 1) / 2])
							sift_toward_root(slot);
						else
							sift_toward_leaves(slot);
					end
				end
			end
			default: ;
		endcase
		if (heap_size > 0) begin
			rep.top_valid  = 1'b1;
			rep.top_id     = heap_tid[0];
			rep.top_expire = heap_key[0];
		end
		rep.entry_count = 7'(heap_size);
		return rep;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// favor small keys so that equal keys meet often
	function automatic logic [KEY_W-1:0] rand_key();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2, 3:    return KEY_W'($urandom_range(0, 7));
			4:       return KEY_W'($urandom_range(0, 1000));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// random id that is live (or free); any id when there is none of that kind
	function automatic logic [ID_W-1:0] pick_id(bit want_live);
		int start;
		int j;
		start = $urandom_range(0, HEAP_IDS - 1);
		for (int i = 0; i < HEAP_IDS; i++) begin
			j = (start + i) % HEAP_IDS;
			if (id_live[j] == want_live)
				return ID_W'(j);
		end
		return ID_W'(start);
	endfunction

	// offer one request, hold it until accepted, then record its result;
	// valid stays high afterward so back-to-back requests need no toggle
	task automatic post_request(input logic [1:0] op, input logic [ID_W-1:0] tid,
			input logic [KEY_W-1:0] key);
		if ($urandom_range(0, 99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			s_tuser  <= IN_USER_W'($urandom);
			s_tdata  <= IN_DATA_W'({$urandom, $urandom, $urandom});
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, key, tid};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		awaited_reports.push_back(apply_timer_op(op, tid, key));
	endtask

	// one random request; push_pct steers the heap toward full or empty
	task automatic issue_random_request(int push_pct);
		if ($urandom_range(0, 99) < 6) begin
			// noise: duplicate push, remove of an absent id, undefined op
			case ($urandom_range(0, 2))
				0:       post_request(OP_PUSH, pick_id(1'b1), rand_key());
				1:       post_request(OP_REMOVE, pick_id(1'b0), {$urandom, $urandom});
				default: post_request(OP_NOP, ID_W'($urandom), {$urandom, $urandom});
			endcase
		end else if ($urandom_range(0, 99) < push_pct) begin
			post_request(OP_PUSH, pick_id(1'b0), rand_key());
		end else if ($urandom_range(0, 1) == 0) begin
			post_request(OP_POP, ID_W'($urandom), {$urandom, $urandom});
		end else begin
			post_request(OP_REMOVE, pick_id(1'b1), {$urandom, $urandom});
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// pop, remove and undefined op on a freshly reset heap
	task automatic test_empty_heap();
		post_request(OP_POP, 6'd0, '0);
		post_request(OP_REMOVE, 6'd0, '0);
		post_request(OP_NOP, 6'd63, '1);
	endtask

	// equal keys: two siblings tie, and the left child wins a pop
	task automatic test_tie_order();
		post_request(OP_PUSH, 6'd11, 64'd7);
		post_request(OP_PUSH, 6'd10, 64'd0);   // rises to the root
		post_request(OP_PUSH, 6'd12, 64'd7);
		post_request(OP_PUSH, 6'd13, 64'd9);
		post_request(OP_POP, 6'd0, '0);        // id 11 must come up, not id 12
		post_request(OP_PUSH, 6'd13, 64'd5);   // id already present
		post_request(OP_NOP, 6'd2, 64'd2);     // reports the top unchanged
		post_request(OP_REMOVE, 6'd11, '0);    // removal at the root moves the last entry up to the root
		post_request(OP_REMOVE, 6'd11, '0);    // already gone
		post_request(OP_REMOVE, 6'd13, '0);    // last node, nothing moves
		post_request(OP_POP, 6'd0, '0);        // back to empty
	endtask

	// removal whose replacement entry must rise, key extremes, tie at the top key
	task automatic test_remove_paths();
		post_request(OP_PUSH, 6'd1, 64'd10);
		post_request(OP_PUSH, 6'd2, 64'd100);
		post_request(OP_PUSH, 6'd3, 64'd20);
		post_request(OP_PUSH, 6'd4, 64'd110);
		post_request(OP_PUSH, 6'd5, '1);
		post_request(OP_PUSH, 6'd6, 64'd30);
		post_request(OP_REMOVE, 6'd4, '0);     // key 30 lands under key 100 and rises
		post_request(OP_PUSH, 6'd63, '1);
		post_request(OP_POP, 6'd0, '0);
		post_request(OP_REMOVE, 6'd5, '0);
	endtask

	// fill to capacity, push into the full heap, then thin it out again
	task automatic test_fill_to_capacity();
		while (heap_size < HEAP_CAP)
			post_request(OP_PUSH, pick_id(1'b0), rand_key());
		repeat (3)
			post_request(OP_PUSH, ID_W'($urandom), rand_key());
		repeat (10) begin
			post_request(OP_REMOVE, pick_id(1'b1), {$urandom, $urandom});
			post_request(OP_POP, ID_W'($urandom), {$urandom, $urandom});
		end
	endtask

	// stall the result side for a long stretch while requests keep coming
	task automatic test_output_backpressure();
		src_gap_pct   = 0;
		sink_hold_len = HOLD_OFF_CYCLES;
		repeat (30)
			issue_random_request(60);
	endtask

	// random mix in segments with their own push bias and idling
	task automatic test_random_mix();
		int push_pct;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				push_pct     = 10 + 20 * $urandom_range(0, 4);
				src_gap_pct  = 15 * $urandom_range(0, 2);
				sink_gap_pct = 15 * $urandom_range(0, 2);
			end
			issue_random_request(push_pct);
		end
	endtask

	// last stretch at full rate on both sides
	task automatic test_unthrottled_tail();
		src_gap_pct  = 0;
		sink_gap_pct = 0;
		for (int n = 0; n < TAIL_ITEMS; n++)
			issue_random_request(n < TAIL_ITEMS / 2 ? 70 : 30);
	endtask

	// ------------------------------------------------------------------------
	// Result side: pacing of tready and checking
	// ------------------------------------------------------------------------

	initial begin : result_pacing
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold_len > 0) begin
				// hold ready low so the block backs up into the request side
				m_tready <= 1'b0;
				repeat (sink_hold_len) @(posedge clk);
				sink_hold_len = 0;
				m_tready <= 1'b1;
			end else if ($urandom_range(0, 99) < sink_gap_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string name, input logic [KEY_W-1:0] want,
			input logic [KEY_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			error_count++;
		end
	endtask

	// compare each accepted result with the oldest prediction
	initial begin : result_check
		heap_report_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (awaited_reports.size() == 0) begin
					$error("result with no request outstanding: %0h / %0h", m_tuser, m_tdata);
					error_count++;
				end else begin
					want = awaited_reports.pop_front();
					check_field("status", want.status, m_tuser);
					check_field("popped_id", want.popped_id, m_tdata[5:0]);
					check_field("popped_expire", want.popped_expire, m_tdata[69:6]);
					check_field("top_valid", want.top_valid, m_tdata[70]);
					check_field("top_id", want.top_id, m_tdata[76:71]);
					check_field("top_expire", want.top_expire, m_tdata[140:77]);
					check_field("entry_count", want.entry_count, m_tdata[147:141]);
				end
			end
		end
	end

	// end the run when neither stream moves for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin : run_tests
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = '0;
		s_tdata  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_heap();
		test_tie_order();
		test_remove_paths();
		test_fill_to_capacity();
		test_output_backpressure();
		test_random_mix();
		test_unthrottled_tail();
		s_tvalid <= 1'b0;

		// drain outstanding results, then give any stray result time to show
		wait (awaited_reports.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
